FILE: sv/ppce_pkg.sv
// Shared types and constants of the particle pair collision engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ppce_pkg;

  // Default parameter values
  localparam int DEF_PARTICLE_COUNT = 4096;
  localparam int DEF_FRAC_BITS      = 16;

  // Field widths fixed by the interface
  localparam int DATA_W = 32;
  localparam int IDX_W  = 12;
  localparam int RAD_W  = 25;
  localparam int RSUM_W = RAD_W + 1;
  localparam int STR_W  = 17;
  localparam int STR_FRAC = 16;

  localparam logic [STR_W-1:0] STRENGTH_RESET = 17'd32768;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Operation codes on the input channel
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COLLIDE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // What the back end has to do with a queued item
  typedef enum logic [1:0] {
    K_NOP,
    K_LOAD,
    K_COLLIDE,
    K_READ
  } kind_t;

  // One classified item as it waits in the queue
  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic [RAD_W-1:0]         radius;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/ppce_front.sv
// Front end: accepts items, classifies them and holds them in a short queue.
// Depends on ppce_pkg.
`default_nettype none

module ppce_front #(
  parameter int PARTICLE_COUNT = ppce_pkg::DEF_PARTICLE_COUNT
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [1:0]                          in_operation,
  input  wire  [ppce_pkg::IDX_W-1:0]          in_index_a,
  input  wire  [ppce_pkg::IDX_W-1:0]          in_index_b,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_pos_x,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_pos_y,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_vel_x,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_vel_y,
  input  wire  [ppce_pkg::RAD_W-1:0]          in_radius,
  output logic                                q_valid,
  output ppce_pkg::cmd_t                      q_head,
  input  wire                                 q_pop
);

  localparam int QD  = ppce_pkg::QUEUE_DEPTH;
  localparam int PTW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CTW = $clog2(QD + 1);

  ppce_pkg::cmd_t  q_r [QD];
  logic [PTW-1:0]  wp_r, rp_r;
  logic [CTW-1:0]  cnt_r;
  logic            ok_a, ok_b, push;
  ppce_pkg::kind_t kind;
  ppce_pkg::cmd_t  entry;

  // Slot indices beyond the store turn the item into a no-op.
  assign ok_a = (32'(in_index_a) < PARTICLE_COUNT);
  assign ok_b = (32'(in_index_b) < PARTICLE_COUNT);

  always_comb begin
    kind = ppce_pkg::K_NOP;
    unique case (in_operation)
      ppce_pkg::OP_LOAD: begin
        if (ok_a) kind = ppce_pkg::K_LOAD;
      end
      ppce_pkg::OP_COLLIDE: begin
        if (ok_a && ok_b && (in_index_a != in_index_b)) kind = ppce_pkg::K_COLLIDE;
      end
      ppce_pkg::OP_READ: begin
        if (ok_a) kind = ppce_pkg::K_READ;
      end
      default: kind = ppce_pkg::K_NOP;
    endcase
  end

  always_comb begin
    entry.kind    = kind;
    entry.index_a = in_index_a;
    entry.index_b = in_index_b;
    entry.pos_x   = in_pos_x;
    entry.pos_y   = in_pos_y;
    entry.vel_x   = in_vel_x;
    entry.vel_y   = in_vel_y;
    entry.radius  = in_radius;
  end

  assign in_ready = (cnt_r != CTW'(QD));
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_r[rp_r];
  assign push     = in_valid && in_ready;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTW'(QD - 1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == PTW'(QD - 1)) ? '0 : rp_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= entry;
  end

endmodule

`default_nettype wire

FILE: sv/ppce_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on ppce_pkg only through the widths handed in.
`default_nettype none

module ppce_sqrt #(
  parameter int RW = ppce_pkg::RSUM_W
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire  [2*RW-1:0]  radicand,
  output logic             done,
  output logic [RW-1:0]    root
);

  localparam int CW = $clog2(RW + 1);

  logic            busy_r, done_r;
  logic [CW-1:0]   cnt_r;
  logic [2*RW-1:0] rad_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [RW+2:0]   rem_sh, trial;
  logic            ge;

  // One digit: bring down two bits and try 4*root+1.
  assign rem_sh = {rem_r[RW:0], rad_r[2*RW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: sv/ppce_div.sv
// Shared restoring divider, one quotient bit per cycle, signed result.
// Depends on ppce_pkg for the default widths.
`default_nettype none

module ppce_div #(
  parameter int RW        = ppce_pkg::RSUM_W,
  parameter int FRAC_BITS = ppce_pkg::DEF_FRAC_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [RW+FRAC_BITS-1:0]      num,
  input  wire  [RW-1:0]                den,
  input  wire                          neg,
  output logic                         done,
  output logic signed [FRAC_BITS+1:0]  quo
);

  localparam int NUM_W = RW + FRAC_BITS;
  localparam int QW    = FRAC_BITS + 2;
  localparam int CW    = $clog2(NUM_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [RW-1:0]    den_r, rem_r;
  logic [RW:0]      rem_sh, diff;
  logic             ge;
  logic [QW-1:0]    mag;

  // Shift in the next dividend bit and subtract where it fits.
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
        num_r  <= num;
        den_r  <= den;
        neg_r  <= neg;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? RW'(diff) : RW'(rem_sh);
        num_r <= {num_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient never exceeds one in the fixed-point scale.
  assign mag  = {1'b0, num_r[FRAC_BITS:0]};
  assign quo  = neg_r ? -$signed(mag) : $signed(mag);
  assign done = done_r;

endmodule

`default_nettype wire

FILE: sv/ppce_back.sv
// Back end: particle store, collision sequencer, shared multiplier and result register.
// Depends on ppce_pkg, ppce_sqrt and ppce_div.
`default_nettype none

module ppce_back #(
  parameter int PARTICLE_COUNT = ppce_pkg::DEF_PARTICLE_COUNT,
  parameter int FRAC_BITS      = ppce_pkg::DEF_FRAC_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [ppce_pkg::STR_W-1:0]          strength,
  input  wire                                 q_valid,
  input  ppce_pkg::cmd_t                      q_head,
  output logic                                q_pop,
  input  wire                                 out_ready,
  output logic                                out_valid,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_pos_x,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_pos_y,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_vel_x,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_vel_y,
  output logic [ppce_pkg::RAD_W-1:0]          out_radius,
  output logic                                out_contact_applied
);

  localparam int AW   = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam int DW   = ppce_pkg::DATA_W;
  localparam int RAW  = ppce_pkg::RAD_W;
  localparam int RW   = ppce_pkg::RSUM_W;
  localparam int D2W  = 2 * RW;
  localparam int NW   = FRAC_BITS + 2;
  localparam int MA_W = 40;
  localparam int MB_W = (NW > RW + 1) ? NW : RW + 1;
  localparam int PW   = MA_W + MB_W;
  localparam logic [D2W-1:0] THRESH = D2W'((64'd1 << (2 * FRAC_BITS)) / 64'd10);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_RDW, S_RDB, S_CAPB, S_DIFF, S_CHK,
    S_SQX, S_SQY, S_SQR, S_CMP, S_SQRT, S_DIVS, S_DIVW,
    S_RN1, S_RN2, S_RN3, S_J0, S_J1, S_J2,
    S_MK, S_MKW, S_MX, S_MY, S_MYW, S_WA, S_WB, S_OUT
  } state_t;

  state_t state_r;

  // Particle store
  logic signed [DW-1:0] px_mem [PARTICLE_COUNT];
  logic signed [DW-1:0] py_mem [PARTICLE_COUNT];
  logic signed [DW-1:0] vx_mem [PARTICLE_COUNT];
  logic signed [DW-1:0] vy_mem [PARTICLE_COUNT];
  logic [RAW-1:0]       rad_mem [PARTICLE_COUNT];

  logic [AW-1:0]        mem_addr;
  logic                 mem_we_pv, mem_we_rad, mem_re;
  logic signed [DW-1:0] w_px, w_py, w_vx, w_vy;
  logic signed [DW-1:0] rd_px_r, rd_py_r, rd_vx_r, rd_vy_r;
  logic [RAW-1:0]       rd_rad_r;

  // Working registers of a collide
  ppce_pkg::cmd_t       cmd_r;
  logic signed [DW-1:0] cur_r [4][2];
  logic signed [DW-1:0] upd_r [4][2];
  logic [RAW-1:0]       ra_r, rb_r;
  logic signed [DW:0]   dx_r, dy_r, rvx_r, rvy_r;
  logic [DW:0]          adx, ady;
  logic [RW-1:0]        rsum_r, dist_r, gap;
  logic signed [NW-1:0] n_r [4];
  logic signed [PW:0]   acc_r;
  logic signed [MA_W-1:0] j_r, sep_r, dv_r, term;
  logic [1:0]           k_r, div_k_r;
  logic [D2W-1:0]       d2, rr;
  logic                 coord;
  logic signed [DW:0]   base;
  logic signed [DW+8:0] sum_v;
  logic signed [RW:0]   rsum_s;
  logic signed [ppce_pkg::STR_W:0] str_s;

  // Shared multiplier
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [PW-1:0]   prod_r;

  // Square root and divider
  logic                    sq_start, sq_done;
  logic [RW-1:0]           sq_root;
  logic                    dv_start, dv_done, dv_neg;
  logic [RW+FRAC_BITS-1:0] dv_num;
  logic [RW-1:0]           dv_den;
  logic signed [NW-1:0]    dv_quo;

  // Result staging and output register
  logic signed [DW-1:0] res_px_r, res_py_r, res_vx_r, res_vy_r;
  logic [RAW-1:0]       res_rad_r;
  logic                 res_contact_r;
  logic                 out_valid_r;

  function automatic logic signed [DW-1:0] sat32(input logic signed [DW+8:0] v);
    logic signed [DW+8:0] hi, lo;
    hi = (DW+9)'($signed({1'b0, {(DW-1){1'b1}}}));
    lo = -hi - 1;
    if (v > hi) return {1'b0, {(DW-1){1'b1}}};
    if (v < lo) return {1'b1, {(DW-1){1'b0}}};
    return DW'(v);
  endfunction

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign adx    = dx_r[DW] ? (DW+1)'(-dx_r) : (DW+1)'(dx_r);
  assign ady    = dy_r[DW] ? (DW+1)'(-dy_r) : (DW+1)'(dy_r);
  assign gap    = rsum_r - dist_r;
  assign rsum_s = $signed({1'b0, rsum_r});
  assign str_s  = $signed({1'b0, strength});
  assign d2     = D2W'(acc_r);
  assign rr     = D2W'(prod_r);

  // Store port control.
  always_comb begin
    mem_addr   = AW'(cmd_r.index_a);
    mem_we_pv  = 1'b0;
    mem_we_rad = 1'b0;
    mem_re     = 1'b0;
    w_px       = cmd_r.pos_x;
    w_py       = cmd_r.pos_y;
    w_vx       = cmd_r.vel_x;
    w_vy       = cmd_r.vel_y;
    unique case (state_r)
      S_EXEC: begin
        if (cmd_r.kind == ppce_pkg::K_LOAD) begin
          mem_we_pv  = 1'b1;
          mem_we_rad = 1'b1;
        end
        if ((cmd_r.kind == ppce_pkg::K_READ) || (cmd_r.kind == ppce_pkg::K_COLLIDE)) begin
          mem_re = 1'b1;
        end
      end
      S_RDB: begin
        mem_addr = AW'(cmd_r.index_b);
        mem_re   = 1'b1;
      end
      S_WA: begin
        mem_we_pv = 1'b1;
        w_px = upd_r[2][0];
        w_py = upd_r[2][1];
        w_vx = upd_r[0][0];
        w_vy = upd_r[0][1];
      end
      S_WB: begin
        mem_addr  = AW'(cmd_r.index_b);
        mem_we_pv = 1'b1;
        w_px = upd_r[3][0];
        w_py = upd_r[3][1];
        w_vx = upd_r[1][0];
        w_vy = upd_r[1][1];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Store arrays with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we_pv) begin
      px_mem[mem_addr] <= w_px;
      py_mem[mem_addr] <= w_py;
      vx_mem[mem_addr] <= w_vx;
      vy_mem[mem_addr] <= w_vy;
    end
    if (mem_we_rad) rad_mem[mem_addr] <= cmd_r.radius;
    if (mem_re) begin
      rd_px_r  <= px_mem[mem_addr];
      rd_py_r  <= py_mem[mem_addr];
      rd_vx_r  <= vx_mem[mem_addr];
      rd_vy_r  <= vy_mem[mem_addr];
      rd_rad_r <= rad_mem[mem_addr];
    end
  end

  // Multiplier operand selection; the product is registered in prod_r.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_SQX: begin
        ma = MA_W'(dx_r);
        mb = MB_W'(dx_r);
      end
      S_SQY: begin
        ma = MA_W'(dy_r);
        mb = MB_W'(dy_r);
      end
      S_SQR: begin
        ma = MA_W'(rsum_s);
        mb = MB_W'(rsum_s);
      end
      S_RN1: begin
        ma = MA_W'(rvx_r);
        mb = MB_W'(n_r[0]);
      end
      S_RN2: begin
        ma = MA_W'(rvy_r);
        mb = MB_W'(n_r[1]);
      end
      S_J0: begin
        ma = MA_W'(acc_r >>> FRAC_BITS);
        mb = MB_W'(str_s);
      end
      S_J1: begin
        ma = MA_W'($signed({1'b0, gap}));
        mb = MB_W'(str_s);
      end
      S_MK: begin
        ma = k_r[1] ? sep_r : j_r;
        mb = MB_W'(n_r[{1'b1, k_r[0]}]);
      end
      S_MX: begin
        ma = dv_r;
        mb = MB_W'(n_r[0]);
      end
      S_MY: begin
        ma = dv_r;
        mb = MB_W'(n_r[1]);
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Saturating update of one component: velocity of a and position of b gain,
  // the other two lose.
  assign coord = (state_r == S_MYW);
  assign term  = MA_W'(prod_r >>> FRAC_BITS);
  assign base  = (DW+1)'(cur_r[k_r][coord]);
  assign sum_v = (k_r[0] ^ k_r[1]) ? (DW+9)'(base) - (DW+9)'(term)
                                   : (DW+9)'(base) + (DW+9)'(term);

  // Divider operands: both normal components, then both radius weights.
  always_comb begin
    dv_num = {adx[RW-1:0], FRAC_BITS'(0)};
    dv_den = dist_r;
    dv_neg = dx_r[DW];
    unique case (div_k_r)
      2'd0: begin
        dv_num = {adx[RW-1:0], FRAC_BITS'(0)};
        dv_neg = dx_r[DW];
      end
      2'd1: begin
        dv_num = {ady[RW-1:0], FRAC_BITS'(0)};
        dv_neg = dy_r[DW];
      end
      2'd2: begin
        dv_num = {1'b0, rb_r, FRAC_BITS'(0)};
        dv_den = rsum_r;
        dv_neg = 1'b0;
      end
      default: begin
        dv_num = {1'b0, ra_r, FRAC_BITS'(0)};
        dv_den = rsum_r;
        dv_neg = 1'b0;
      end
    endcase
  end

  // The squared distance can carry one bit more than the squared radius sum,
  // so the upper bound is tested on the full accumulator.
  assign dv_start = (state_r == S_DIVS);
  assign sq_start = (state_r == S_CMP) && (acc_r < (PW+1)'(rr)) && (d2 > THRESH);

  ppce_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (d2),
    .done     (sq_done),
    .root     (sq_root)
  );

  ppce_div #(.RW(RW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .neg   (dv_neg),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // Sequencer, working registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      div_k_r     <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_px_r      <= '0;
          res_py_r      <= '0;
          res_vx_r      <= '0;
          res_vy_r      <= '0;
          res_rad_r     <= '0;
          res_contact_r <= 1'b0;
          unique case (cmd_r.kind)
            ppce_pkg::K_READ:    state_r <= S_RDW;
            ppce_pkg::K_COLLIDE: state_r <= S_RDB;
            default:             state_r <= S_OUT;
          endcase
        end
        S_RDW: begin
          res_px_r  <= rd_px_r;
          res_py_r  <= rd_py_r;
          res_vx_r  <= rd_vx_r;
          res_vy_r  <= rd_vy_r;
          res_rad_r <= rd_rad_r;
          state_r   <= S_OUT;
        end
        S_RDB: begin
          cur_r[0][0] <= rd_vx_r;
          cur_r[0][1] <= rd_vy_r;
          cur_r[2][0] <= rd_px_r;
          cur_r[2][1] <= rd_py_r;
          ra_r        <= rd_rad_r;
          state_r     <= S_CAPB;
        end
        S_CAPB: begin
          cur_r[1][0] <= rd_vx_r;
          cur_r[1][1] <= rd_vy_r;
          cur_r[3][0] <= rd_px_r;
          cur_r[3][1] <= rd_py_r;
          rb_r        <= rd_rad_r;
          state_r     <= S_DIFF;
        end
        S_DIFF: begin
          dx_r    <= (DW+1)'(cur_r[3][0]) - (DW+1)'(cur_r[2][0]);
          dy_r    <= (DW+1)'(cur_r[3][1]) - (DW+1)'(cur_r[2][1]);
          rvx_r   <= (DW+1)'(cur_r[1][0]) - (DW+1)'(cur_r[0][0]);
          rvy_r   <= (DW+1)'(cur_r[1][1]) - (DW+1)'(cur_r[0][1]);
          rsum_r  <= RW'(ra_r) + RW'(rb_r);
          state_r <= S_CHK;
        end
        S_CHK: begin
          // Coarse box test keeps the squares within the multiplier.
          if ((rsum_r == '0) || (adx >= (DW+1)'(rsum_r)) || (ady >= (DW+1)'(rsum_r))) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          acc_r   <= (PW+1)'(prod_r);
          state_r <= S_SQR;
        end
        S_SQR: begin
          acc_r   <= acc_r + (PW+1)'(prod_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          state_r <= sq_start ? S_SQRT : S_OUT;
        end
        S_SQRT: begin
          if (sq_done) begin
            dist_r  <= sq_root;
            div_k_r <= '0;
            state_r <= S_DIVS;
          end
        end
        S_DIVS: state_r <= S_DIVW;
        S_DIVW: begin
          if (dv_done) begin
            n_r[div_k_r] <= dv_quo;
            div_k_r      <= div_k_r + 1'b1;
            state_r      <= (div_k_r == 2'd3) ? S_RN1 : S_DIVS;
          end
        end
        S_RN1: state_r <= S_RN2;
        S_RN2: begin
          acc_r   <= (PW+1)'(prod_r);
          state_r <= S_RN3;
        end
        S_RN3: begin
          acc_r   <= acc_r + (PW+1)'(prod_r);
          state_r <= S_J0;
        end
        S_J0: state_r <= S_J1;
        S_J1: begin
          j_r     <= MA_W'(prod_r >>> ppce_pkg::STR_FRAC);
          state_r <= S_J2;
        end
        S_J2: begin
          sep_r   <= MA_W'(prod_r >>> ppce_pkg::STR_FRAC);
          k_r     <= '0;
          state_r <= S_MK;
        end
        S_MK: state_r <= S_MKW;
        S_MKW: begin
          dv_r    <= term;
          state_r <= S_MX;
        end
        S_MX: state_r <= S_MY;
        S_MY: begin
          upd_r[k_r][0] <= sat32(sum_v);
          state_r       <= S_MYW;
        end
        S_MYW: begin
          upd_r[k_r][1] <= sat32(sum_v);
          k_r           <= k_r + 1'b1;
          state_r       <= (k_r == 2'd3) ? S_WA : S_MK;
        end
        S_WA: state_r <= S_WB;
        S_WB: begin
          res_contact_r <= 1'b1;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_pos_x           <= res_px_r;
            out_pos_y           <= res_py_r;
            out_vel_x           <= res_vx_r;
            out_vel_y           <= res_vy_r;
            out_radius          <= res_rad_r;
            out_contact_applied <= res_contact_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: sv/particle_pair_collision_engine_core.sv
// Particle pair collision engine: top level with the strength register.
// Depends on ppce_pkg, ppce_front and ppce_back.
//
// Use: items arrive on the in_ channel (valid/ready) and name an operation:
// load a particle slot, read a slot, or collide a pair of slots. Every item
// gives exactly one result item on the out_ channel (valid/ready); a read
// returns the slot, a collide reports in out_contact_applied whether the
// pair overlapped and was updated, all other fields are zero.
// The cfg_ channel writes the collision strength; it is always ready and
// should only be written while no item is in flight.
// A load or a read goes from the queue to the result register without the
// square root or divider. A collide that makes contact waits on the shared
// bit-serial divider, which forms four quotients in turn, and on the
// 26-step square root; a pair rejected early uses neither.
// Items are carried out one at a time; a two-item queue in front takes new
// items while the back end works or waits on a stalled receiver, and the
// result register holds a finished item until out_ready.
// Reset clears the queue, the sequencer and the output register and sets the
// strength to 0.5; the particle store is not cleared and holds nothing
// defined until a slot is loaded.
`default_nettype none

module particle_pair_collision_engine_core #(
  parameter int PARTICLE_COUNT = ppce_pkg::DEF_PARTICLE_COUNT,
  parameter int FRAC_BITS      = ppce_pkg::DEF_FRAC_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [1:0]                          in_operation,
  input  wire  [ppce_pkg::IDX_W-1:0]          in_index_a,
  input  wire  [ppce_pkg::IDX_W-1:0]          in_index_b,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_pos_x,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_pos_y,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_vel_x,
  input  wire  signed [ppce_pkg::DATA_W-1:0]  in_vel_y,
  input  wire  [ppce_pkg::RAD_W-1:0]          in_radius,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_pos_x,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_pos_y,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_vel_x,
  output logic signed [ppce_pkg::DATA_W-1:0]  out_vel_y,
  output logic [ppce_pkg::RAD_W-1:0]          out_radius,
  output logic                                out_contact_applied,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [ppce_pkg::STR_W-1:0]          cfg_data
);

  logic [ppce_pkg::STR_W-1:0] strength_r;
  logic                       q_valid, q_pop;
  ppce_pkg::cmd_t             q_head;

  // Collision strength register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= ppce_pkg::STRENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      strength_r <= cfg_data;
    end
  end

  ppce_front #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_index_a   (in_index_a),
    .in_index_b   (in_index_b),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_vel_x     (in_vel_x),
    .in_vel_y     (in_vel_y),
    .in_radius    (in_radius),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  ppce_back #(.PARTICLE_COUNT(PARTICLE_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .strength            (strength_r),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_pos_x           (out_pos_x),
    .out_pos_y           (out_pos_y),
    .out_vel_x           (out_vel_x),
    .out_vel_y           (out_vel_y),
    .out_radius          (out_radius),
    .out_contact_applied (out_contact_applied)
  );

endmodule

`default_nettype wire
